// File: design/itrd_pkg.sv
// Shared types, constants and the digit-to-character function of the radix converter.
package itrd_pkg;

   localparam int BASE_W  = 6;
   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 7;

   localparam logic [BASE_W-1:0]  BASE_MIN   = 6'd2;
   localparam logic [BASE_W-1:0]  BASE_MAX   = 6'd36;
   localparam logic [BASE_W-1:0]  BASE_RESET = 6'd10;

   localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 7'd65;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_STORE,
      ST_READ,
      ST_LOAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic store;
      logic load_out;
      logic next_digit;
   } dp_cmd_type;

   typedef struct packed {
      logic quot_zero;
      logic last;
   } dp_sts_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = {1'b0, d};
      if (d <= DIGIT_NINE) begin
         return CHAR_ZERO + d_ext;
      end else begin
         return CHAR_ALPHA + d_ext - {1'b0, DIGIT_TEN};
      end
   endfunction

endpackage

// File: design/itrd_req_if.sv
// Input channel: value words with valid/ready handshake.
interface itrd_req_if #(
   parameter int VALUE_BITS = 31
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// File: design/itrd_rsp_if.sv
// Result channel: one ASCII digit per word with valid/ready handshake.
interface itrd_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] digit_char;
   logic       last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// File: design/itrd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itrd_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 31
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: design/itrd_ctrl.sv
// Sequencer: division step count, digit store and read-out handshake.
module itrd_ctrl #(
   parameter int VALUE_BITS = 31
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output itrd_pkg::dp_cmd_type cmd,
   input  itrd_pkg::dp_sts_type sts
);
   import itrd_pkg::*;

   localparam int SW = $clog2(VALUE_BITS);
   localparam logic [SW-1:0] STEP_LAST = SW'(VALUE_BITS - 1);

   state_type state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DIVIDE;
         ST_DIVIDE: if (step_ff == STEP_LAST) state_in = ST_STORE;
         ST_STORE:  state_in = sts.quot_zero ? ST_READ : ST_DIVIDE;
         ST_READ:   state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_EMIT;
         ST_EMIT:   if (rsp_ready) state_in = sts.last ? ST_IDLE : ST_READ;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      cmd            = '0;
      step_in        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_ff != STEP_LAST) step_in = step_ff + 1'b1;
         end
         ST_STORE: cmd.store    = 1'b1;
         ST_READ:  ;
         ST_LOAD:  cmd.load_out = 1'b1;
         ST_EMIT: begin
            rsp_valid      = 1'b1;
            cmd.next_digit = rsp_ready & ~sts.last;
         end
         default: ;
      endcase
   end

   a_accept_starts_division: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DIVIDE && step_ff == '0))
      else $error("accepted word did not start a division");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && sts.last) |=> req_ready)
      else $error("final digit taken but not ready for next word");

   a_stalled_digit_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("stalled digit dropped");
endmodule

// File: design/itrd_dp.sv
// Datapath: base register, bit-serial restoring divider, digit store and output register.
module itrd_dp #(
   parameter int VALUE_BITS = 31
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [itrd_pkg::BASE_W-1:0]   csr_wdata,
   input  logic [VALUE_BITS-1:0]         value,
   input  itrd_pkg::dp_cmd_type          cmd,
   output itrd_pkg::dp_sts_type          sts,
   output logic [itrd_pkg::CHAR_W-1:0]   digit_char,
   output logic                          last_digit
);
   import itrd_pkg::*;

   localparam int AW = $clog2(VALUE_BITS);

   logic [BASE_W-1:0]     base_ff, base_in;
   logic [VALUE_BITS-1:0] quot_ff, quot_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic                  last_ff, last_in;
   logic [DIGIT_W:0]      trial;
   logic                  fits;
   logic [DIGIT_W:0]      trial_sub;
   logic [DIGIT_W-1:0]    ram_rdata;

   // Shift in the next dividend bit; subtract the base when it fits.
   assign trial     = {rem_ff, quot_ff[VALUE_BITS-1]};
   assign fits      = trial >= {1'b0, base_ff};
   assign trial_sub = trial - {1'b0, base_ff};

   always_comb begin
      base_in   = base_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      if (csr_we && (csr_wdata inside {[BASE_MIN:BASE_MAX]})) base_in = csr_wdata;
      if (cmd.load) begin
         quot_in   = value;
         rem_in    = '0;
         wr_ptr_in = '0;
      end
      if (cmd.div_step) begin
         quot_in = {quot_ff[VALUE_BITS-2:0], fits};
         rem_in  = fits ? trial_sub[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      end
      if (cmd.store) begin
         rem_in = '0;
         if (quot_ff == '0) rd_ptr_in = wr_ptr_ff;
         else               wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (cmd.load_out) begin
         char_in = digit_to_ascii(ram_rdata);
         last_in = (rd_ptr_ff == '0);
      end
      if (cmd.next_digit) rd_ptr_in = rd_ptr_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else begin
         base_ff <= base_in;
      end
      quot_ff   <= quot_in;
      rem_ff    <= rem_in;
      wr_ptr_ff <= wr_ptr_in;
      rd_ptr_ff <= rd_ptr_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   // Remainders land least significant first; read back from the top down.
   itrd_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (VALUE_BITS)
   ) u_digits (
      .clock (clock),
      .we    (cmd.store),
      .waddr (wr_ptr_ff),
      .wdata (rem_ff),
      .raddr (rd_ptr_ff),
      .rdata (ram_rdata)
   );

   assign sts.quot_zero = (quot_ff == '0);
   assign sts.last      = last_ff;
   assign digit_char    = char_ff;
   assign last_digit    = last_ff;

   a_base_in_range: assert property (@(posedge clock) disable iff (reset)
      (base_ff >= BASE_MIN) && (base_ff <= BASE_MAX))
      else $error("base register out of range");

   a_base_write: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_wdata >= BASE_MIN && csr_wdata <= BASE_MAX) |=> base_ff == $past(csr_wdata))
      else $error("legal base write not taken");

   a_wr_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> (wr_ptr_ff <= AW'(VALUE_BITS - 1)))
      else $error("digit store pointer past depth");
endmodule

// File: design/integer_to_radix_digits_unit.sv
// Top level of the integer to radix digit string converter.
//
//  channel   dir  handshake      payload
//  req_bus   in   valid/ready    value[VALUE_BITS-1:0]
//  rsp_bus   out  valid/ready    digit_char[6:0], last_digit
//  csr_*     in   csr_we         csr_wdata[5:0] (base, 2..36; other writes ignored)
//
// One word at a time. Each digit comes from a full bit-serial divider pass (ST_DIVIDE,
// ST_STORE); each digit is then read from the digit RAM (ST_READ, ST_LOAD) and
// presented (ST_EMIT) until taken, so the output may stall.
// Synchronous reset sets the base to 10 and returns the sequencer to idle; no clearing pass.
// A stalled result holds its digit; req_bus.ready stays low until the final digit is taken.
module integer_to_radix_digits_unit #(
   parameter int VALUE_BITS = 31
) (
   input  logic                        clock,
   input  logic                        reset,
   itrd_req_if.sink                    req_bus,
   itrd_rsp_if.source                  rsp_bus,
   input  logic                        csr_we,
   input  logic [itrd_pkg::BASE_W-1:0] csr_wdata
);
   import itrd_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   itrd_ctrl #(
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   itrd_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .value      (req_bus.value),
      .cmd        (cmd),
      .sts        (sts),
      .digit_char (rsp_bus.digit_char),
      .last_digit (rsp_bus.last_digit)
   );
endmodule

// File: sim/tb_integer_to_radix_digits_unit.sv
// Testbench for the integer to radix digit string converter: directed and random values.
module tb_integer_to_radix_digits_unit;
   import itrd_pkg::*;

   localparam int VALUE_BITS    = 31;
   localparam int SETTLE_CYCLES = 16;
   localparam int TAIL_CYCLES   = 1100;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int GAP_PERCENT   = 24;
   localparam int MAX_REPORTS   = 10;
   localparam logic [VALUE_BITS-1:0] VALUE_ALL_ONES = '1;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last_digit;
   } digit_word_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [BASE_W-1:0]   csr_wdata;

   itrd_req_if #(.VALUE_BITS(VALUE_BITS)) req_bus ();
   itrd_rsp_if                            rsp_bus ();

   integer_to_radix_digits_unit #(
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus.sink),
      .rsp_bus   (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   digit_word_type    digits_due[$];
   logic [BASE_W-1:0] radix_model;
   bit                gaps_on;
   int                fault_count;
   int                cycle_count;

   always #1 clock = ~clock;

   // Expected digit string of one value in the current radix, most significant first.
   function automatic void predict_digits(input logic [VALUE_BITS-1:0] value);
      logic [DIGIT_W-1:0] rems [0:VALUE_BITS-1];
      longint unsigned    rest;
      int                 n;
      digit_word_type     w;
      rest = value;
      n    = 0;
      if (rest == 0) begin
         rems[0] = '0;
         n       = 1;
      end
      while (rest != 0) begin
         rems[n] = DIGIT_W'(rest % radix_model);
         rest    = rest / radix_model;
         n++;
      end
      for (int k = n - 1; k >= 0; k--) begin
         if (rems[k] < DIGIT_TEN) begin
            w.digit_char = CHAR_ZERO + CHAR_W'(rems[k]);
         end else begin
            w.digit_char = CHAR_ALPHA + CHAR_W'(rems[k] - DIGIT_TEN);
         end
         w.last_digit = (k == 0);
         digits_due.push_back(w);
      end
   endfunction

   function automatic logic [VALUE_BITS-1:0] random_value();
      int unsigned pick;
      int unsigned len;
      pick = $urandom_range(99);
      len  = $urandom_range(VALUE_BITS, 1);
      if (pick < 15) begin
         return VALUE_BITS'($urandom_range(40, 0));
      end
      if (pick < 35) begin
         return VALUE_BITS'($urandom >> (32 - VALUE_BITS));
      end
      // Vary the bit length so every digit count shows up.
      return VALUE_BITS'($urandom >> (32 - len));
   endfunction

   task automatic note_fault(input string what);
      fault_count++;
      if (fault_count <= MAX_REPORTS) begin
         $display("mismatch: %s", what);
      end
   endtask

   // Ends on the accepting rising edge; the next call starts at a fresh falling edge.
   task automatic send_value(input logic [VALUE_BITS-1:0] value);
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      predict_digits(value);
   endtask

   task automatic drain_digits(input int settle);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (digits_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_radix(input logic [BASE_W-1:0] radix);
      drain_digits(SETTLE_CYCLES);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= radix;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (radix >= BASE_MIN && radix <= BASE_MAX) begin
         radix_model = radix;
      end
   endtask

   task automatic check_reset_radix();
      send_value('0);
      send_value(VALUE_BITS'(1));
      send_value(VALUE_BITS'(9));
      send_value(VALUE_BITS'(10));
      send_value(VALUE_ALL_ONES);
      send_value(VALUE_BITS'(1000000));
   endtask

   task automatic check_radix_extremes();
      write_radix(BASE_MIN);
      send_value('0);
      send_value(VALUE_BITS'(1));
      send_value(VALUE_ALL_ONES);
      send_value(VALUE_BITS'(1) << (VALUE_BITS - 1));
      send_value(VALUE_BITS'(32'h2AAA_AAAA));
      write_radix(BASE_MAX);
      send_value(VALUE_BITS'(35));
      send_value(VALUE_BITS'(36));
      send_value(VALUE_ALL_ONES);
      send_value('0);
      send_value(VALUE_BITS'(1295));
   endtask

   // Out-of-range writes must leave the radix alone.
   task automatic check_rejected_radix();
      write_radix(BASE_W'(16));
      write_radix(BASE_W'(0));
      send_value(VALUE_BITS'(32'h2BAD_F00D));
      write_radix(BASE_W'(1));
      send_value(VALUE_BITS'(32'h1234_5678));
      write_radix(BASE_MAX + BASE_W'(1));
      send_value(VALUE_BITS'(32'h5555_5555));
      write_radix('1);
      send_value(VALUE_BITS'(255));
   endtask

   task automatic check_random_values();
      logic [BASE_W-1:0] radix;
      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: radix = BASE_MIN;
            1: radix = BASE_MAX;
            2: radix = BASE_RESET;
            3: radix = BASE_W'(16);
            4: radix = BASE_W'(8);
            default: radix = BASE_W'($urandom_range(BASE_MAX, BASE_MIN));
         endcase
         write_radix(radix);
         // Run one phase flat out with no gaps on either side.
         gaps_on = (phase != 4);
         repeat (23) send_value(random_value());
      end
      gaps_on = 1'b1;
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= !gaps_on || ($urandom_range(99) >= GAP_PERCENT);
   end

   always @(posedge clock) begin : check_digits
      digit_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (digits_due.size() == 0) begin
            note_fault($sformatf("unexpected word, char %0d last %0b",
                                 rsp_bus.digit_char, rsp_bus.last_digit));
         end else begin
            want = digits_due.pop_front();
            if (rsp_bus.digit_char !== want.digit_char ||
                rsp_bus.last_digit !== want.last_digit) begin
               note_fault($sformatf("expected char %0d last %0b, got char %0d last %0b",
                                    want.digit_char, want.last_digit,
                                    rsp_bus.digit_char, rsp_bus.last_digit));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      gaps_on       = 1'b1;
      fault_count   = 0;
      cycle_count   = 0;
      radix_model   = BASE_RESET;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      check_reset_radix();
      check_radix_extremes();
      check_rejected_radix();
      check_random_values();

      drain_digits(TAIL_CYCLES);
      if (fault_count == 0 && digits_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
design/itrd_pkg.sv
design/itrd_req_if.sv
design/itrd_rsp_if.sv
design/itrd_ram.sv
design/itrd_ctrl.sv
design/itrd_dp.sv
design/integer_to_radix_digits_unit.sv
sim/tb_integer_to_radix_digits_unit.sv
